@@ rtl/core/cru_pkg.sv @@
// ----------------------------------------------------------------------------
// cru_pkg
// Shared types, constants and filter coefficients of the 2x chroma row
// upsampler.
// ----------------------------------------------------------------------------
package cru_pkg;

    localparam int MAX_ROW_SAMPLES = 4096;
    localparam int LEN_W           = $clog2(MAX_ROW_SAMPLES + 1);
    localparam int POS_W           = $clog2(MAX_ROW_SAMPLES);
    localparam int QUEUE_DEPTH     = 2;  // power of two
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_JOBS        = 8;
    localparam int COEF_W          = 9;
    localparam int SUM_W           = 20;

    // configuration register indexes
    localparam logic CFG_ROW_WIDTH  = 1'b0;
    localparam logic CFG_ROW_STRIDE = 1'b1;

    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(3);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_ROW_SAMPLES);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

    // one pixel job each; order is the emission order
    typedef enum logic [2:0] {
        JOB_LEAD0,
        JOB_LEAD1,
        JOB_LEAD2,
        JOB_INT0,
        JOB_INT1,
        JOB_TRAIL0,
        JOB_TRAIL1,
        JOB_TRAIL2
    } t_job;

    typedef logic [NUM_JOBS-1:0] t_job_mask;

    typedef struct packed {
        logic [7:0] w0;
        logic [7:0] w1;
        logic [7:0] w2;
        logic [7:0] cur;
        t_job_mask  jobs;
    } t_entry;

    typedef struct packed {
        logic signed [COEF_W-1:0] k0;
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic signed [COEF_W-1:0] k3;
    } t_coef;

    // taps applied to w0, w1, w2 and the current sample
    function automatic t_coef cru_coef(input t_job job);
        t_coef c;
        case (job)
            JOB_LEAD0:  c = '{9'sd0,   9'sd139, -9'sd11,  9'sd0};
            JOB_LEAD1:  c = '{9'sd0,   9'sd104, 9'sd27,   -9'sd3};
            JOB_LEAD2:  c = '{9'sd0,   9'sd28,  9'sd109,  -9'sd9};
            JOB_INT0:   c = '{-9'sd9,  9'sd111, 9'sd29,   -9'sd3};
            JOB_INT1:   c = '{-9'sd3,  9'sd29,  9'sd111,  -9'sd9};
            JOB_TRAIL0: c = '{9'sd0,   -9'sd9,  9'sd109,  9'sd28};
            JOB_TRAIL1: c = '{9'sd0,   -9'sd3,  9'sd27,   9'sd104};
            JOB_TRAIL2: c = '{9'sd0,   9'sd0,   -9'sd11,  9'sd139};
            default:    c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] cru_clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v < LEN_MIN) begin
            r = LEN_MIN;
        end else if (v > LEN_MAX) begin
            r = LEN_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/cru_in_if.sv @@
// ----------------------------------------------------------------------------
// cru_in_if
// Sample channel: one 8-bit chroma sample per word.
// ----------------------------------------------------------------------------
interface cru_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

@@ rtl/core/cru_out_if.sv @@
// ----------------------------------------------------------------------------
// cru_out_if
// Pixel channel: one upsampled pixel per word with row and run markers.
// ----------------------------------------------------------------------------
interface cru_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       row_done;
    logic       run_last;

    modport source (output valid, output pixel_value, output row_done, output run_last,
                    input ready);
    modport sink   (input valid, input pixel_value, input row_done, input run_last,
                    output ready);
endinterface

@@ rtl/core/cru_front.sv @@
// ----------------------------------------------------------------------------
// cru_front
// Takes samples, keeps the window and row position, and classifies each
// sample into the set of pixel jobs it triggers.
// ----------------------------------------------------------------------------
module cru_front import cru_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [LEN_W-1:0] i_cfg_data,
    input  logic             i_valid,
    input  logic [7:0]       i_sample,
    output logic             o_ready,
    input  logic             i_q_full,
    output logic             o_push,
    output t_entry           o_entry
);

    logic [LEN_W-1:0] r_width;
    logic [LEN_W-1:0] r_stride;
    logic [7:0]       r_win0, r_win1, r_win2;
    logic [POS_W-1:0] r_pos;

    logic [LEN_W-1:0] stride_c;
    logic [LEN_W-1:0] width_cl;
    logic [LEN_W-1:0] width_c;
    logic [LEN_W-1:0] pos_ext;
    logic             lead, inter, trail;
    logic             accept;
    t_job_mask        jobs;

    assign stride_c = cru_clamp_len(r_stride);
    assign width_cl = cru_clamp_len(r_width);
    assign width_c  = (width_cl > stride_c) ? stride_c : width_cl;
    assign pos_ext  = LEN_W'(r_pos);

    assign lead  = (pos_ext == LEN_W'(2));
    assign inter = (pos_ext >= LEN_W'(3)) && (pos_ext < width_c);
    assign trail = (pos_ext >= stride_c - LEN_W'(1));

    always_comb begin
        jobs                 = '0;
        jobs[JOB_LEAD0]      = lead;
        jobs[JOB_LEAD1]      = lead;
        jobs[JOB_LEAD2]      = lead;
        jobs[JOB_INT0]       = inter;
        jobs[JOB_INT1]       = inter;
        jobs[JOB_TRAIL0]     = trail;
        jobs[JOB_TRAIL1]     = trail;
        jobs[JOB_TRAIL2]     = trail;
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (jobs != '0);
    assign o_entry = '{w0: r_win0, w1: r_win1, w2: r_win2, cur: i_sample, jobs: jobs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= LEN_RESET;
            r_stride <= LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_WIDTH:  r_width  <= i_cfg_data;
                CFG_ROW_STRIDE: r_stride <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
            r_win2 <= '0;
            r_pos  <= '0;
        end else if (accept) begin
            r_win0 <= r_win1;
            r_win1 <= r_win2;
            r_win2 <= i_sample;
            r_pos  <= trail ? '0 : r_pos + POS_W'(1);
        end
    end

endmodule

@@ rtl/core/cru_queue.sv @@
// ----------------------------------------------------------------------------
// cru_queue
// Short job queue between the classifier and the pixel engine.
// ----------------------------------------------------------------------------
module cru_queue import cru_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_head
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/core/cru_back.sv @@
// ----------------------------------------------------------------------------
// cru_back
// Pixel engine: works through the job mask of one entry, one filtered pixel
// per cycle into the output register while that register is free.
// ----------------------------------------------------------------------------
module cru_back import cru_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_entry     i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_pixel,
    output logic       o_row_done,
    output logic       o_run_last
);

    logic       r_busy;
    t_entry     r_ent;
    logic       r_out_valid;
    logic [7:0] r_pixel;
    logic       r_row_done;
    logic       r_run_last;

    t_job                    sel;
    t_job_mask               rest;
    t_coef                   c;
    logic signed [SUM_W-1:0] p0, p1, p2, p3;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-7-1:0]      quo;
    logic [7:0]              pix;
    logic                    out_free, issue, done_entry, load;

    // lowest pending job goes first
    always_comb begin
        sel = JOB_TRAIL2;
        for (int i = NUM_JOBS - 1; i >= 0; i--) begin
            if (r_ent.jobs[i]) begin
                sel = t_job'(i);
            end
        end
    end

    assign rest = r_ent.jobs & (r_ent.jobs - t_job_mask'(1));
    assign c    = cru_coef(sel);

    assign p0 = SUM_W'(c.k0 * $signed({1'b0, r_ent.w0}));
    assign p1 = SUM_W'(c.k1 * $signed({1'b0, r_ent.w1}));
    assign p2 = SUM_W'(c.k2 * $signed({1'b0, r_ent.w2}));
    assign p3 = SUM_W'(c.k3 * $signed({1'b0, r_ent.cur}));
    assign sum = p0 + p1 + p2 + p3 + SUM_W'(64);
    assign quo = sum[SUM_W-1:7];

    always_comb begin
        if (sum[SUM_W-1]) begin
            pix = '0;
        end else if (quo > (SUM_W-7)'(255)) begin
            pix = 8'hFF;
        end else begin
            pix = quo[7:0];
        end
    end

    assign out_free   = !r_out_valid || i_ready;
    assign issue      = r_busy && out_free;
    assign done_entry = issue && (rest == '0);
    assign load       = i_q_valid && (!r_busy || done_entry);
    assign o_pop      = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (done_entry) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ent <= i_head;
        end else if (issue) begin
            r_ent.jobs <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (issue) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pixel    <= pix;
            r_row_done <= (sel == JOB_TRAIL2);
            r_run_last <= (rest == '0);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_pixel    = r_pixel;
    assign o_row_done = r_row_done;
    assign o_run_last = r_run_last;

endmodule

@@ rtl/core/chroma_row_upsampler_2x.sv @@
// ----------------------------------------------------------------------------
// chroma_row_upsampler_2x
// Horizontal 2x chroma upsampler: 4-tap interior filter, 2/3-tap edges.
//
//   channel  | dir | words                       | handshake
//   i_in     | in  | sample_value                | valid/ready
//   o_out    | out | pixel_value,row_done,run_last| valid/ready
//   i_cfg_*  | in  | row_width, row_stride       | write enable only
//
// The engine makes one pixel per cycle while its output register is free;
// a sample yields 0, 2, 3, 5 or 6 pixels, two on average if width = stride.
// Samples are taken while the two-entry job queue has room; a sample that
// yields nothing is also taken every cycle while the queue has room.
// Output pixels leave from a register; a stalled output holds its word and
// the queue keeps taking samples until it fills.
// Synchronous reset clears window, position, queue and output valid.
// ----------------------------------------------------------------------------
module chroma_row_upsampler_2x import cru_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [LEN_W-1:0] i_cfg_data,
    cru_in_if.sink           i_in,
    cru_out_if.source        o_out
);

    logic   push, q_full, q_valid, pop;
    t_entry entry, head;

    cru_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in.valid),
        .i_sample   (i_in.sample_value),
        .o_ready    (i_in.ready),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (entry)
    );

    cru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    cru_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_pixel    (o_out.pixel_value),
        .o_row_done (o_out.row_done),
        .o_run_last (o_out.run_last)
    );

endmodule

@@ rtl/core/cru_checker.sv @@
// ----------------------------------------------------------------------------
// cru_checker
// Port-level checks of the chroma row upsampler.
// ----------------------------------------------------------------------------
module cru_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_pixel,
    input logic       i_out_row_done,
    input logic       i_out_run_last,
    input logic       i_in_ready
);

    // a stalled word must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pixel)
            && $stable(i_out_row_done) && $stable(i_out_run_last))
        else $error("output word changed under stall");

    // the closing pixel of a row is always the last of its sample's run
    a_row_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_row_done |-> i_out_run_last)
        else $error("row_done without run_last");

    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("output valid or input stalled straight after reset");

endmodule

bind chroma_row_upsampler_2x cru_checker u_cru_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_pixel    (o_out.pixel_value),
    .i_out_row_done (o_out.row_done),
    .i_out_run_last (o_out.run_last),
    .i_in_ready     (i_in.ready)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2x chroma row upsampler. Samples go in over the
// valid/ready sample channel while an in-bench predictor works out the pixel
// words each accepted sample must yield; every pixel word that leaves is
// compared field by field with the oldest prediction. Covers edge filters,
// clipping, clamped and crossed lengths, config changes mid-row, a long
// output stall, random rows and lengths at the top of the range.
// ----------------------------------------------------------------------------
module tb_top;
    import cru_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_SAMPLES = 100;

    typedef struct {
        logic [7:0] pixel;
        logic       row_done;
        logic       run_last;
    } t_pixel_word;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [LEN_W-1:0] i_cfg_data;

    cru_in_if  in_ch();
    cru_out_if out_ch();

    chroma_row_upsampler_2x u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // predictor state
    logic [LEN_W-1:0] cfg_row_width;
    logic [LEN_W-1:0] cfg_row_stride;
    logic [7:0]       sample_win [3];
    int               row_pos;

    t_pixel_word pending_pixels [$];
    int          mismatch_count;
    int          sent_samples;
    int          stall_cycles;
    bit          src_idle_en;
    bit          snk_idle_en;
    bit          hold_req;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int clamp_len(input logic [LEN_W-1:0] v);
        if (v < 3) begin
            return 3;
        end
        if (v > MAX_ROW_SAMPLES) begin
            return MAX_ROW_SAMPLES;
        end
        return int'(v);
    endfunction

    function automatic logic [7:0] round_clip(input int s);
        int r;
        r = s + 64;
        if (r < 0) begin
            return 8'd0;
        end
        r = r >>> 7;
        return (r > 255) ? 8'hFF : 8'(r);
    endfunction

    function automatic logic [7:0] rand_sample();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0: begin
                v = 8'h00;
            end
            1: begin
                v = 8'hFF;
            end
            default: begin
                v = 8'($urandom_range(0, 255));
            end
        endcase
        return v;
    endfunction

    task automatic predict_pixels(input logic [7:0] cur_s);
        t_pixel_word words [6];
        int n, w0, w1, w2, cur, width, stride;
        n      = 0;
        w0     = sample_win[0];
        w1     = sample_win[1];
        w2     = sample_win[2];
        cur    = cur_s;
        stride = clamp_len(cfg_row_stride);
        width  = clamp_len(cfg_row_width);
        if (width > stride) begin
            width = stride;
        end
        if (row_pos == 2) begin
            words[n] = '{round_clip(139 * w1 - 11 * w2), 1'b0, 1'b0};
            n = n + 1;
            words[n] = '{round_clip(104 * w1 + 27 * w2 - 3 * cur), 1'b0, 1'b0};
            n = n + 1;
            words[n] = '{round_clip(28 * w1 + 109 * w2 - 9 * cur), 1'b0, 1'b0};
            n = n + 1;
        end
        if (row_pos >= 3 && row_pos < width) begin
            words[n] = '{round_clip(-9 * w0 + 111 * w1 + 29 * w2 - 3 * cur), 1'b0, 1'b0};
            n = n + 1;
            words[n] = '{round_clip(-3 * w0 + 29 * w1 + 111 * w2 - 9 * cur), 1'b0, 1'b0};
            n = n + 1;
        end
        // trailing edge always reads the end of the stride, not of the width
        if (row_pos >= stride - 1) begin
            words[n] = '{round_clip(28 * cur + 109 * w2 - 9 * w1), 1'b0, 1'b0};
            n = n + 1;
            words[n] = '{round_clip(104 * cur + 27 * w2 - 3 * w1), 1'b0, 1'b0};
            n = n + 1;
            words[n] = '{round_clip(139 * cur - 11 * w2), 1'b1, 1'b0};
            n = n + 1;
            row_pos = 0;
        end else begin
            row_pos = row_pos + 1;
        end
        sample_win[0] = sample_win[1];
        sample_win[1] = sample_win[2];
        sample_win[2] = cur_s;
        if (n > 0) begin
            words[n-1].run_last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            pending_pixels = {pending_pixels, words[i]};
        end
    endtask

    // predictor, checker and stall count in one process: no ordering issues
    always @(posedge i_clk) begin : monitor
        t_pixel_word exp_w;
        if (!i_rst_n) begin
            cfg_row_width  = LEN_W'(8);
            cfg_row_stride = LEN_W'(8);
            sample_win     = '{8'd0, 8'd0, 8'd0};
            row_pos        = 0;
            stall_cycles   = 0;
            pending_pixels.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected word pix=%0d done=%0b last=%0b", $realtime,
                                 out_ch.pixel_value, out_ch.row_done, out_ch.run_last);
                    end
                end else begin
                    exp_w = pending_pixels.pop_front();
                    if (exp_w.pixel !== out_ch.pixel_value || exp_w.row_done !== out_ch.row_done
                        || exp_w.run_last !== out_ch.run_last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"%0t: exp pix=%0d done=%0b last=%0b, ",
                                      "got pix=%0d done=%0b last=%0b"},
                                     $realtime, exp_w.pixel, exp_w.row_done, exp_w.run_last,
                                     out_ch.pixel_value, out_ch.row_done, out_ch.run_last);
                        end
                    end
                end
            end
            // a word taken on the same edge as a register write sees the old lengths
            if (in_ch.valid && in_ch.ready) begin
                predict_pixels(in_ch.sample_value);
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ROW_WIDTH) begin
                    cfg_row_width = i_cfg_data;
                end else begin
                    cfg_row_stride = i_cfg_data;
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // output side: random back-pressure, plus one long hold-off on request
    initial begin : pixel_sink
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = snk_idle_en ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready) && !hold_req);
        end
    end

    task automatic send_sample(input logic [7:0] v);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_samples++;
    endtask

    task automatic send_row(input int count);
        repeat (count) send_sample(rand_sample());
    endtask

    // the extra cycles cover samples still in flight that yield no word
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input int width, input int stride);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ROW_WIDTH;
        i_cfg_data <= LEN_W'(width);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ROW_STRIDE;
        i_cfg_data <= LEN_W'(stride);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // reset lengths, min lengths, clamped lengths, width past stride, clipping
    task automatic test_edge_cases();
        logic [7:0] row_a [8] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255};
        logic [7:0] row_b [3] = '{8'd255, 8'd0, 8'd255};
        logic [7:0] row_c [5] = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0};
        logic [7:0] row_d [5] = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd255};
        logic [7:0] row_e [3] = '{8'd0, 8'd255, 8'd0};
        foreach (row_a[i]) send_sample(row_a[i]);
        wait_drained();
        write_config(3, 3);
        foreach (row_b[i]) send_sample(row_b[i]);
        wait_drained();
        write_config(3, 5);
        foreach (row_c[i]) send_sample(row_c[i]);
        wait_drained();
        write_config(8191, 5);
        foreach (row_d[i]) send_sample(row_d[i]);
        wait_drained();
        write_config(0, 2);
        foreach (row_e[i]) send_sample(row_e[i]);
        wait_drained();
    endtask

    task automatic test_midrow_config();
        write_config(10, 16);
        send_row(9);
        wait_drained();
        // position already past the new stride end: next sample closes the row
        write_config(10, 6);
        send_row(8);
        wait_drained();
        write_config(4, 12);
        send_row(6);
        wait_drained();
        write_config(12, 12);
        send_row(5);
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_config(6, 8);
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        send_row(40);
        wait_drained();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_row(16);
        wait_drained();
    endtask

    task automatic test_random_rows();
        int stop_at, w, s, pick;
        stop_at = sent_samples + RANDOM_SAMPLES;
        while (sent_samples < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                w = $urandom_range(3, 12);
                s = w + $urandom_range(0, 4);
            end else if (pick < 9) begin
                s = $urandom_range(3, 8);
                w = s + $urandom_range(1, 8);
            end else begin
                w = $urandom_range(0, 2);
                s = $urandom_range(0, 2);
            end
            wait_drained();
            write_config(w, s);
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4)) send_row(clamp_len(LEN_W'(s)));
            // now and then leave a row open across the next config change
            if ($urandom_range(0, 4) == 0) begin
                send_row($urandom_range(1, clamp_len(LEN_W'(s)) - 1));
            end
        end
        wait_drained();
    endtask

    // lengths clamped to the top of the range, then a short stride closes the row
    task automatic test_max_row();
        write_config(MAX_ROW_SAMPLES, 8191);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        send_row(24);
        wait_drained();
        write_config(8, 8);
        send_row(9);
        wait_drained();
    endtask

    initial begin : stimulus
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_ROW_WIDTH;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.sample_value <= 8'd0;
        mismatch_count = 0;
        sent_samples   = 0;
        src_idle_en    = 1'b1;
        snk_idle_en    = 1'b1;
        hold_req       = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_cases();
        test_midrow_config();
        test_backpressure();
        test_random_rows();
        test_max_row();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/cru_pkg.sv
rtl/core/cru_in_if.sv
rtl/core/cru_out_if.sv
rtl/core/cru_front.sv
rtl/core/cru_queue.sv
rtl/core/cru_back.sv
rtl/core/chroma_row_upsampler_2x.sv
rtl/core/cru_checker.sv
tb/tb_top.sv
